>>> rtl/tksk_pkg.sv
package tksk_pkg;

  // One stored candidate: score first, key second.
  typedef struct packed {
    logic signed [31:0] score;
    logic        [31:0] key;
  } entry_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_SHIFT = 6'b000100,
    ST_WRITE = 6'b001000,
    ST_RESP  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  typedef enum logic [0:0] {
    CMD_OFFER   = 1'b0,
    CMD_READOUT = 1'b1
  } cmd_e;

  // Register word index taken from paddr[2].
  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0,
    REG_NONE     = 1'b1
  } reg_e;

  localparam int unsigned RESULT_LIMIT = 16;
  localparam logic [4:0]  CAP_RESET    = 5'd16;
  localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;

endpackage

>>> rtl/top_k_score_keeper_dedup.sv
// Channel   Dir  Handshake               Payload
// in        in   in_valid_i/in_ready_o   command_i, score_i, cand_key_i
// out       out  out_valid_o/out_ready_i accepted_o, entry_valid_o, entry_score_o,
//                                        entry_key_o, last_o, best_score_o
// cfg       in   psel/penable/pwrite     paddr[2:0], pwdata, prdata, pready
//
// Offer: the item is accepted, the duplicate scan reads the stored entries from the tail
// toward the head, the insertion shift moves each lower-scoring entry down one place,
// and then the response beat is posted. When the store is full the lowest entry is
// overwritten, never moved. The entry RAM has a single read port, so the scan and the
// shift read one entry at a time. Readout gives one beat per entry (one beat if empty).
// Reset empties the store through the count alone; no clearing pass is needed.
// A stalled output holds the sequencer; a new item is taken while the last beat waits.
module top_k_score_keeper_dedup #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  logic signed [31:0]  score_i,
  input  logic [31:0]         cand_key_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                accepted_o,
  output logic                entry_valid_o,
  output logic signed [31:0]  entry_score_o,
  output logic [31:0]         entry_key_o,
  output logic                last_o,
  output logic signed [31:0]  best_score_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import tksk_pkg::*;

  localparam int unsigned AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMPW = (CW > 5) ? CW : 5;
  localparam logic [CW-1:0]   MAX_C   = CW'(MAX_ENTRIES);
  localparam logic [CMPW-1:0] MAX_X   = CMPW'(MAX_ENTRIES);
  localparam logic [CMPW-1:0] LIMIT_X = CMPW'(RESULT_LIMIT);

  state_e             state_q, state_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic signed [31:0] best_q, best_d;
  logic [4:0]         cap_q;
  logic signed [31:0] score_q;
  logic [31:0]        key_q;
  logic               acc_q, acc_d;

  // output register
  logic               out_valid_q;
  logic               acc_out_q, valid_out_q, last_out_q;
  logic signed [31:0] score_out_q, best_out_q;
  logic [31:0]        key_out_q;
  logic               load_out, out_free;
  logic               nx_acc, nx_valid, nx_last;
  logic signed [31:0] nx_score;
  logic [31:0]        nx_key;

  // RAM port
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  entry_t             wr_data, rd_entry;

  logic [AW-1:0]      first_addr;
  logic [CW-1:0]      n0;
  logic [CMPW-1:0]    cap_eff, ins_cnt, n_lim;
  logic               s_gt, reject, cfg_wr;

  tksk_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_entry)
  );

  // Configuration port: no wait states (pready is tied high), one register at word 0.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (reg_e'(paddr[2]) == REG_CAPACITY);

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_CAPACITY: prdata = {27'd0, cap_q};
      default:      prdata = 32'd0;
    endcase
  end

  // Derived limits. The tail entry is the lowest; when full it is the one dropped.
  assign first_addr = AW'(cnt_q - 1'b1);
  assign n0         = (cnt_q >= MAX_C) ? CW'(MAX_C - 1'b1) : cnt_q;
  assign cap_eff    = (CMPW'(cap_q) > MAX_X) ? MAX_X : CMPW'(cap_q);
  assign ins_cnt    = CMPW'(n0) + 1'b1;
  assign n_lim      = (CMPW'(cnt_q) > LIMIT_X) ? LIMIT_X : CMPW'(cnt_q);
  assign s_gt       = score_q > rd_entry.score;
  assign reject     = (rd_entry.key == key_q) || ((idx_q == first_addr) && !s_gt);
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  function automatic logic signed [31:0] s_gt_best(input logic signed [31:0] s,
                                                   input logic signed [31:0] b);
    s_gt_best = (s > b) ? s : b;
  endfunction

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    best_d   = best_q;
    acc_d    = acc_q;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = pos_q;
    wr_data  = '{score: score_q, key: key_q};
    load_out = 1'b0;
    nx_acc   = 1'b0;
    nx_valid = 1'b0;
    nx_score = '0;
    nx_key   = '0;
    nx_last  = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_e'(command_i) == CMD_OFFER) begin
            if (cnt_q == '0) begin
              // empty store: insert at the head without a scan
              pos_d   = '0;
              best_d  = (score_i > best_q) ? score_i : best_q;
              state_d = ST_WRITE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = first_addr;
              idx_d   = first_addr;
              state_d = ST_SCAN;
            end
          end else begin
            if (cnt_q == '0) begin
              acc_d   = 1'b0;
              state_d = ST_RESP;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              idx_d   = '0;
              state_d = ST_EMIT;
            end
          end
        end
      end

      ST_SCAN: begin
        // walk from the tail to the head looking for the key
        if (reject) begin
          acc_d   = 1'b0;
          state_d = ST_RESP;
        end else if (idx_q == '0) begin
          best_d = s_gt_best(score_q, best_q);
          pos_d  = AW'(n0);
          if (n0 == '0) begin
            state_d = ST_WRITE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AW'(n0 - 1'b1);
            state_d = ST_SHIFT;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_q - 1'b1);
          idx_d   = AW'(idx_q - 1'b1);
        end
      end

      ST_SHIFT: begin
        // rd_entry is entry pos-1; move it down while it scores below the newcomer
        if (rd_entry.score < score_q) begin
          wr_en   = 1'b1;
          wr_addr = pos_q;
          wr_data = rd_entry;
          pos_d   = AW'(pos_q - 1'b1);
          if (pos_q == AW'(1)) begin
            state_d = ST_WRITE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AW'(pos_q - 2'd2);
          end
        end else begin
          wr_en   = 1'b1;
          cnt_d   = (ins_cnt > cap_eff) ? CW'(cap_eff) : CW'(ins_cnt);
          acc_d   = 1'b1;
          state_d = ST_RESP;
        end
      end

      ST_WRITE: begin
        wr_en   = 1'b1;
        cnt_d   = (ins_cnt > cap_eff) ? CW'(cap_eff) : CW'(ins_cnt);
        acc_d   = 1'b1;
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          load_out = 1'b1;
          nx_acc   = acc_q;
          state_d  = ST_IDLE;
        end
      end

      ST_EMIT: begin
        // rd_entry holds entry idx until the next read is issued
        if (out_free) begin
          load_out = 1'b1;
          nx_valid = 1'b1;
          nx_score = rd_entry.score;
          nx_key   = rd_entry.key;
          nx_last  = ((CMPW'(idx_q) + 1'b1) == n_lim);
          if (nx_last) begin
            state_d = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AW'(idx_q + 1'b1);
            idx_d   = AW'(idx_q + 1'b1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      best_q      <= SCORE_MIN;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      best_q  <= best_d;
      if (cfg_wr) begin
        cap_q <= pwdata[4:0];
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and sequencer working registers need no reset.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    pos_q <= pos_d;
    acc_q <= acc_d;
    if (in_valid_i && in_ready_o) begin
      score_q <= score_i;
      key_q   <= cand_key_i;
    end
    if (load_out) begin
      acc_out_q   <= nx_acc;
      valid_out_q <= nx_valid;
      score_out_q <= nx_score;
      key_out_q   <= nx_key;
      last_out_q  <= nx_last;
      best_out_q  <= best_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = acc_out_q;
  assign entry_valid_o = valid_out_q;
  assign entry_score_o = score_out_q;
  assign entry_key_o   = key_out_q;
  assign last_o        = last_out_q;
  assign best_score_o  = best_out_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_C)
    else $error("entry count above store depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE))
    else $error("sequencer idle right after taking an item");

  a_best_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (best_q >= $past(best_q)))
    else $error("best score dropped");

  a_offer_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && accepted_o) |-> (!entry_valid_o && last_o))
    else $error("offer beat carries an entry or is not last");
`endif

endmodule

>>> rtl/tksk_ram.sv
module tksk_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                         wr_data_i,
  input  logic                                     rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
